// File: hdl/scvl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvl_pkg
// shared constants, codes and types of the sorted curve value lookup
// ----------------------------------------------------------------------------
package scvl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS = 32;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W = 11;
  localparam int STYLE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = COUNT_W;
  localparam int ENTRY_W = 2 * SAMPLE_BITS;

  // plot styles
  localparam logic [STYLE_W-1:0] STYLE_LINES   = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_LAGGING = 2'd1;
  localparam logic [STYLE_W-1:0] STYLE_LEADING = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_STYLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd2;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // operands of one interpolation between points i and j
  typedef struct packed {
    sample_t q;
    sample_t xi;
    sample_t yi;
    sample_t xj;
    sample_t yj;
  } lerp_req_t;

endpackage

// File: hdl/sorted_curve_value_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_curve_value_lookup_core
// piecewise linear curve lookup over a table of points sorted by x
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): a write request stores one point
//   (x, y) at in_point_index and returns nothing; a query request returns one
//   result on the out channel: curve value at in_query_x, or no_data when
//   point_count is zero. points must be loaded in ascending x order.
//   cfg port: plot_style, interpolate, point_count; written while idle.
// query steps
//   a write is stored in the table when it is taken. a query runs from one table read per cycle in
//   a single ram: the end checks on the first and last points, then the halving steps
//   of the binary search (up to 11 steps at 1024 points), reads of the
//   bracketing points, and when interpolating one multiply and a 32-step serial
//   divide (the divide is skipped when the quotient saturates).
// throughput
//   one query in flight; in_stall stays high until its result is in the
//   output register. the next request is taken while that result waits.
// reset
//   synchronous, active low: control and config return to defaults
//   (lines, interpolate on, empty table). table contents are kept.
// stall
//   out_stall holds the result in the output register; a finished query then
//   waits and the input side stays stalled.
// ----------------------------------------------------------------------------
module sorted_curve_value_lookup_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [scvl_pkg::IDX_W-1:0]    in_point_index,
  input  scvl_pkg::sample_t             in_point_x,
  input  scvl_pkg::sample_t             in_point_y,
  input  scvl_pkg::sample_t             in_query_x,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scvl_pkg::sample_t             out_curve_value,
  output logic                          out_no_data,
  input  logic                          cfg_wr_en,
  input  logic [scvl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scvl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import scvl_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHK_FIRST = 4'd1;
  localparam logic [3:0] S_CHK_LAST  = 4'd2;
  localparam logic [3:0] S_PROBE     = 4'd3;
  localparam logic [3:0] S_CMP       = 4'd4;
  localparam logic [3:0] S_PICK      = 4'd5;
  localparam logic [3:0] S_GET_I     = 4'd6;
  localparam logic [3:0] S_GET_J     = 4'd7;
  localparam logic [3:0] S_LERP      = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [STYLE_W-1:0] style_r;
  logic               interp_r;
  logic [COUNT_W-1:0] count_r;

  sample_t            q_r, q_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  sample_t            xi_r, xi_nxt;
  sample_t            yi_r, yi_nxt;
  sample_t            res_value_r, res_value_nxt;
  logic               res_no_data_r, res_no_data_nxt;

  logic               out_valid_r;
  sample_t            out_value_r;
  logic               out_no_data_r;

  logic               in_accept, out_load;
  logic [CNT_W-1:0]   n_in, last_idx, half, mid, pick_idx;
  logic               go_right, lerp_mode;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  sample_t            rd_x, rd_y;

  logic               lerp_start, lerp_done;
  lerp_req_t          lerp_req;
  sample_t            lerp_value;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ram_we    = in_accept && (in_req_type == REQ_WRITE);

  assign n_in     = (count_r > COUNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(count_r);
  assign last_idx = n_r - CNT_W'(1);
  assign half     = len_r >> 1;
  assign mid      = first_r + half;
  assign rd_x     = rd_data_x(ram_rdata);
  assign rd_y     = ram_rdata[SAMPLE_BITS-1:0];

  function automatic sample_t rd_data_x(input logic [ENTRY_W-1:0] e);
    return e[ENTRY_W-1:SAMPLE_BITS];
  endfunction

  // upper-bound search except for leading stairs
  assign go_right  = (style_r == STYLE_LEADING) ? (rd_x < q_r) : (rd_x <= q_r);
  assign lerp_mode = interp_r && (style_r != STYLE_LEADING) && (style_r != STYLE_LAGGING);

  always_comb begin
    if (style_r == STYLE_LEADING) begin
      pick_idx = (first_r > last_idx) ? last_idx : first_r;
    end else begin
      pick_idx = (first_r == '0) ? '0 : first_r - CNT_W'(1);
    end
  end

  always_comb begin
    unique case (state_r)
      S_CHK_FIRST: ram_raddr = last_idx[IDX_W-1:0];
      S_PROBE:     ram_raddr = mid[IDX_W-1:0];
      S_PICK:      ram_raddr = pick_idx[IDX_W-1:0];
      S_GET_I:     ram_raddr = idx_r + IDX_W'(1);
      default:     ram_raddr = '0;
    endcase
  end

  assign lerp_req = '{q: q_r, xi: xi_r, yi: yi_r, xj: rd_x, yj: rd_y};
  assign lerp_start = (state_r == S_GET_J) && (rd_x != xi_r);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt       = state_r;
    q_nxt           = q_r;
    n_nxt           = n_r;
    first_nxt       = first_r;
    len_nxt         = len_r;
    idx_nxt         = idx_r;
    xi_nxt          = xi_r;
    yi_nxt          = yi_r;
    res_value_nxt   = res_value_r;
    res_no_data_nxt = res_no_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_req_type == REQ_QUERY)) begin
          q_nxt = in_query_x;
          n_nxt = n_in;
          if (n_in == '0) begin
            res_value_nxt   = '0;
            res_no_data_nxt = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            res_no_data_nxt = 1'b0;
            state_nxt       = S_CHK_FIRST;
          end
        end
      end
      S_CHK_FIRST: begin
        if ((n_r == CNT_W'(1)) || (q_r <= rd_x)) begin
          res_value_nxt = rd_y;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (q_r >= rd_x) begin
          res_value_nxt = rd_y;
          state_nxt     = S_DONE;
        end else begin
          first_nxt = '0;
          len_nxt   = n_r;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = (len_r == '0) ? S_PICK : S_CMP;
      end
      S_CMP: begin
        if (go_right) begin
          first_nxt = mid + CNT_W'(1);
          len_nxt   = len_r - half - CNT_W'(1);
        end else begin
          len_nxt = half;
        end
        state_nxt = S_PROBE;
      end
      S_PICK: begin
        idx_nxt   = pick_idx[IDX_W-1:0];
        state_nxt = S_GET_I;
      end
      S_GET_I: begin
        xi_nxt = rd_x;
        yi_nxt = rd_y;
        // no upper neighbor at the last point
        if (lerp_mode && ({1'b0, idx_r} != last_idx)) begin
          state_nxt = S_GET_J;
        end else begin
          res_value_nxt = rd_y;
          state_nxt     = S_DONE;
        end
      end
      S_GET_J: begin
        if (rd_x == xi_r) begin
          res_value_nxt = yi_r;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_LERP;
        end
      end
      S_LERP: begin
        if (lerp_done) begin
          res_value_nxt = lerp_value;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      style_r  <= STYLE_LINES;
      interp_r <= 1'b1;
      count_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_PLOT_STYLE:  style_r  <= cfg_wdata[STYLE_W-1:0];
          REG_INTERPOLATE: interp_r <= cfg_wdata[0];
          REG_POINT_COUNT: count_r  <= cfg_wdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r           <= q_nxt;
    n_r           <= n_nxt;
    first_r       <= first_nxt;
    len_r         <= len_nxt;
    idx_r         <= idx_nxt;
    xi_r          <= xi_nxt;
    yi_r          <= yi_nxt;
    res_value_r   <= res_value_nxt;
    res_no_data_r <= res_no_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r   <= res_value_r;
      out_no_data_r <= res_no_data_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_value_r;
  assign out_no_data     = out_no_data_r;

  scvl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_point_index),
    .wdata ({in_point_x, in_point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scvl_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .req   (lerp_req),
    .done  (lerp_done),
    .value (lerp_value)
  );

endmodule

// File: hdl/scvl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvl_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module scvl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/scvl_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvl_lerp
// linear interpolation: one multiply, then a bit-serial divide and saturation
// ----------------------------------------------------------------------------
module scvl_lerp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  scvl_pkg::lerp_req_t req,
  output logic               done,
  output scvl_pkg::sample_t  value
);

  import scvl_pkg::*;

  localparam int DCNT_W = $clog2(SAMPLE_BITS);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_CHK  = 3'd2;
  localparam logic [2:0] L_DIV  = 3'd3;
  localparam logic [2:0] L_OUT  = 3'd4;

  localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [2:0]               state_r, state_nxt;
  logic [SAMPLE_BITS-1:0]   dy_r, dq_r, dx_r;
  logic                     neg_r;
  logic [SAMPLE_BITS-1:0]   y0b_r;
  logic [2*SAMPLE_BITS-1:0] prod_r;
  logic [SAMPLE_BITS-1:0]   rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]   quo_r, quo_nxt;
  logic [DCNT_W-1:0]        cnt_r;
  logic                     sat_r;

  logic [SAMPLE_BITS:0]     dy_d, dq_d, dx_d;
  logic [SAMPLE_BITS:0]     dy_a, dq_a, dx_a;
  logic [SAMPLE_BITS:0]     trial, trial_sub;
  logic                     trial_ge;
  logic [SAMPLE_BITS-1:0]   res_b;

  // wide differences, sign bit on top
  assign dy_d = {req.yj[SAMPLE_BITS-1], req.yj} - {req.yi[SAMPLE_BITS-1], req.yi};
  assign dq_d = {req.q[SAMPLE_BITS-1], req.q} - {req.xi[SAMPLE_BITS-1], req.xi};
  assign dx_d = {req.xj[SAMPLE_BITS-1], req.xj} - {req.xi[SAMPLE_BITS-1], req.xi};
  assign dy_a = dy_d[SAMPLE_BITS] ? -dy_d : dy_d;
  assign dq_a = dq_d[SAMPLE_BITS] ? -dq_d : dq_d;
  assign dx_a = dx_d[SAMPLE_BITS] ? -dx_d : dx_d;

  // restoring divide step
  assign trial     = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign trial_ge  = trial >= {1'b0, dx_r};
  assign trial_sub = trial - {1'b0, dx_r};
  assign rem_nxt   = trial_ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
  assign quo_nxt   = {quo_r[SAMPLE_BITS-2:0], trial_ge};

  // offset-binary result, clamped at both ends
  always_comb begin
    if (neg_r) begin
      res_b = (sat_r || quo_r > y0b_r) ? '0 : y0b_r - quo_r;
    end else begin
      res_b = (sat_r || quo_r > ~y0b_r) ? '1 : y0b_r + quo_r;
    end
  end

  assign done  = (state_r == L_OUT);
  assign value = sample_t'(res_b ^ SIGN_BIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (start) state_nxt = L_MUL;
      L_MUL:  state_nxt = L_CHK;
      L_CHK:  state_nxt = (prod_r[2*SAMPLE_BITS-1:SAMPLE_BITS] >= dx_r) ? L_OUT : L_DIV;
      L_DIV:  if (cnt_r == DCNT_W'(SAMPLE_BITS - 1)) state_nxt = L_OUT;
      L_OUT:  state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      L_IDLE: begin
        dy_r  <= dy_a[SAMPLE_BITS-1:0];
        dq_r  <= dq_a[SAMPLE_BITS-1:0];
        dx_r  <= dx_a[SAMPLE_BITS-1:0];
        neg_r <= dy_d[SAMPLE_BITS] ^ dq_d[SAMPLE_BITS] ^ dx_d[SAMPLE_BITS];
        y0b_r <= req.yi ^ SIGN_BIT;
      end
      L_MUL: begin
        prod_r <= dy_r * dq_r;
      end
      L_CHK: begin
        // a quotient of full width or more always saturates
        sat_r <= prod_r[2*SAMPLE_BITS-1:SAMPLE_BITS] >= dx_r;
        rem_r <= prod_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
        quo_r <= prod_r[SAMPLE_BITS-1:0];
        cnt_r <= '0;
      end
      L_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + DCNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/scvl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvl_checker
// port-level checks of the curve lookup, bound to the top level
// ----------------------------------------------------------------------------
module scvl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_req_type,
  input logic [scvl_pkg::IDX_W-1:0]     in_point_index,
  input scvl_pkg::sample_t              in_point_x,
  input scvl_pkg::sample_t              in_point_y,
  input scvl_pkg::sample_t              in_query_x,
  input logic                           out_valid,
  input logic                           out_stall,
  input scvl_pkg::sample_t              out_curve_value,
  input logic                           out_no_data,
  input logic                           cfg_wr_en,
  input logic [scvl_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [scvl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import scvl_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_curve_value) && $stable(out_no_data))
    else $error("result changed while stalled");

  // empty-table results carry a zero value
  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_data |-> out_curve_value == '0)
    else $error("no_data result with nonzero value");

  // a query blocks further requests until its result is out
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_QUERY) |=> in_stall)
    else $error("request taken while a query is in flight");

  // a write request never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_WRITE) && !out_valid |=> !out_valid)
    else $error("result appeared after a write request");

endmodule

bind sorted_curve_value_lookup_core scvl_checker u_scvl_checker (.*);
